@@ rtl/rsmm_pkg.sv @@
// package for the rational sum, max and min block: widths, states and shared types
package rsmm_pkg;

    localparam int InWidth  = 32;
    localparam int AccWidth = 64;
    localparam int WideW    = 96;
    localparam int MagW     = 33;
    localparam int CntW     = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_GCD_PRE,
        ST_GCD_ODD_A,
        ST_GCD_LOOP,
        ST_GCD_SHL,
        ST_DIV_N,
        ST_DIV_D,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [AccWidth-1:0]   sum_num;
        logic [AccWidth-2:0]   sum_den;
        logic signed [MagW-1:0] max_num;
        logic [InWidth-1:0]    max_den;
        logic signed [MagW-1:0] min_num;
        logic [InWidth-1:0]    min_den;
        logic                  ovf;
        logic                  bad;
    } t_result;

    typedef struct packed {
        logic start;
        logic done;
    } t_ctl;

endpackage

@@ rtl/rsmm_div.sv @@
// restoring divider, one quotient bit per cycle over 96 bits
module rsmm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsmm_pkg::t_ctl                i_ctl,
    input  logic [rsmm_pkg::WideW-1:0]    i_num,
    input  logic [rsmm_pkg::WideW-1:0]    i_den,
    output logic                          o_done,
    output logic [rsmm_pkg::WideW-1:0]    o_quo
);
    logic [rsmm_pkg::WideW-1:0] r_rem, r_quo, r_den;
    logic [rsmm_pkg::CntW:0]    r_cnt;
    logic                       r_busy;
    logic [rsmm_pkg::WideW:0]   w_sh;

    assign w_sh   = {r_rem, r_quo[rsmm_pkg::WideW-1]};
    assign o_quo  = r_quo;
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= (rsmm_pkg::CntW+1)'(rsmm_pkg::WideW);
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= rsmm_pkg::WideW'(w_sh - {1'b0, r_den});
                r_quo <= {r_quo[rsmm_pkg::WideW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[rsmm_pkg::WideW-1:0];
                r_quo <= {r_quo[rsmm_pkg::WideW-2:0], 1'b0};
            end
        end else if (i_ctl.done) begin
            r_busy <= 1'b0;
        end
    end
endmodule

@@ rtl/rational_sum_max_min.sv @@
// top level: rational accumulator with gcd reduction and running max and min
// steps: shift-add multiply, binary gcd by shift and subtract, then two divisions by the gcd
// throughput: one item at a time, next input taken the cycle after the result is registered
// a zero denominator goes from the multiply state straight to output, a zero sum skips gcd and divisions
// synchronous active-low reset clears sum to 0/1, max and min to 0/1, the sum overflow flag to 0
module rational_sum_max_min (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // numerator, denominator
    input  logic         s_axis_tlast,  // last_item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [263:0] m_axis_tdata,  // sum_num, sum_den, max_num, max_den, min_num, min_den
    output logic [1:0]   m_axis_tuser   // sum_overflow, bad_input
);
    localparam int W = rsmm_pkg::WideW;
    localparam int A = rsmm_pkg::AccWidth;
    localparam int M = rsmm_pkg::MagW;
    localparam int I = rsmm_pkg::InWidth;

    rsmm_pkg::t_state r_st, n_st;

    logic [A-1:0]   r_acc_num;
    logic [A-1:0]   r_acc_den;
    logic signed [M-1:0] r_hi_num, r_lo_num;
    logic [I:0]     r_hi_den, r_lo_den;
    logic           r_ovf, r_started, r_last, r_bad;
    logic           r_fs;
    logic [I:0]     r_mn, r_md;
    logic [W-1:0]   r_t1, r_t2, r_den, r_mag, r_ga, r_gb, r_qn;
    logic [W-1:0]   r_xa, r_xb;
    logic [I:0]     r_ym, r_yd;
    logic           r_sg;
    logic [rsmm_pkg::CntW-1:0] r_k;
    logic           r_ovl;
    rsmm_pkg::t_result r_res;

    rsmm_pkg::t_ctl w_dctl;
    logic           w_ddone;
    logic [W-1:0]   w_quo, w_dnum;
    logic [I:0]     w_mn, w_md;
    logic           w_nneg, w_dneg;
    logic [A-1:0]   w_am;
    logic signed [2*M+1:0] w_p1, w_p2, w_p3, w_p4;
    logic [A-1:0]   w_lim;
    logic           w_out_go;

    assign w_nneg = s_axis_tdata[I-1];
    assign w_dneg = s_axis_tdata[2*I-1];
    assign w_mn   = w_nneg ? (I+1)'(-{1'b1, s_axis_tdata[I-1:0]}) : {1'b0, s_axis_tdata[I-1:0]};
    assign w_md   = w_dneg ? (I+1)'(-{1'b1, s_axis_tdata[2*I-1:I]}) : {1'b0, s_axis_tdata[2*I-1:I]};
    assign w_am   = r_acc_num[A-1] ? (~r_acc_num + 1'b1) : r_acc_num;
    assign w_lim  = {1'b0, {(A-1){1'b1}}};

    assign s_axis_tready = (r_st == rsmm_pkg::ST_IDLE);
    assign w_out_go      = (r_st == rsmm_pkg::ST_OUT) && (!m_axis_tvalid || m_axis_tready);

    assign w_dctl.start = (r_st == rsmm_pkg::ST_GCD_SHL && r_k == '0)
                          || (r_st == rsmm_pkg::ST_DIV_N && w_ddone);
    assign w_dctl.done  = w_ddone;
    assign w_dnum       = (r_st == rsmm_pkg::ST_GCD_SHL) ? r_mag : r_den;

    rsmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dctl),
        .i_num   (w_dnum),
        .i_den   (r_ga),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    logic signed [M-1:0] w_sn;
    assign w_sn = r_fs ? -M'(r_mn) : M'(r_mn);
    assign w_p1 = (2*M+2)'(w_sn) * (2*M+2)'($signed({1'b0, r_hi_den}));
    assign w_p2 = (2*M+2)'(r_hi_num) * (2*M+2)'($signed({1'b0, r_md}));
    assign w_p3 = (2*M+2)'(w_sn) * (2*M+2)'($signed({1'b0, r_lo_den}));
    assign w_p4 = (2*M+2)'(r_lo_num) * (2*M+2)'($signed({1'b0, r_md}));

    always_comb begin
        n_st = r_st;
        case (r_st)
            rsmm_pkg::ST_IDLE:      if (s_axis_tvalid && s_axis_tready) n_st = rsmm_pkg::ST_MUL;
            rsmm_pkg::ST_MUL:       if (r_bad) n_st = rsmm_pkg::ST_OUT;
                                    else if (r_k == (rsmm_pkg::CntW)'(I)) n_st = rsmm_pkg::ST_ADD;
            rsmm_pkg::ST_ADD:       n_st = rsmm_pkg::ST_GCD_PRE;
            rsmm_pkg::ST_GCD_PRE:   if (r_mag == '0) n_st = rsmm_pkg::ST_CMP;
                                    else if (r_ga[0] | r_gb[0]) n_st = rsmm_pkg::ST_GCD_ODD_A;
            rsmm_pkg::ST_GCD_ODD_A: if (r_ga[0]) n_st = rsmm_pkg::ST_GCD_LOOP;
            rsmm_pkg::ST_GCD_LOOP:  if (r_gb[0] && r_ga == r_gb) n_st = rsmm_pkg::ST_GCD_SHL;
            rsmm_pkg::ST_GCD_SHL:   if (r_k == '0) n_st = rsmm_pkg::ST_DIV_N;
            rsmm_pkg::ST_DIV_N:     if (w_ddone) n_st = rsmm_pkg::ST_DIV_D;
            rsmm_pkg::ST_DIV_D:     if (w_ddone) n_st = rsmm_pkg::ST_CMP;
            rsmm_pkg::ST_CMP:       n_st = rsmm_pkg::ST_OUT;
            rsmm_pkg::ST_OUT:       if (w_out_go) n_st = rsmm_pkg::ST_IDLE;
            default:                n_st = rsmm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st          <= rsmm_pkg::ST_IDLE;
            r_acc_num     <= '0;
            r_acc_den     <= A'(1);
            r_hi_num      <= '0;
            r_hi_den      <= (I+1)'(1);
            r_lo_num      <= '0;
            r_lo_den      <= (I+1)'(1);
            r_ovf         <= 1'b0;
            r_started     <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_out_go) m_axis_tvalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            case (r_st)
                rsmm_pkg::ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_mn   <= w_mn;
                        r_md   <= w_md;
                        r_fs   <= (w_nneg != w_dneg) && (w_mn != '0);
                        r_bad  <= (w_md == '0);
                        r_last <= s_axis_tlast;
                        r_xa   <= W'(w_am);
                        r_xb   <= W'(r_acc_den);
                        r_ym   <= w_mn;
                        r_yd   <= w_md;
                        r_t1   <= '0;
                        r_t2   <= '0;
                        r_den  <= '0;
                        r_k    <= '0;
                    end
                end
                rsmm_pkg::ST_MUL: begin
                    // shift-add, one multiplier bit per cycle
                    if (r_yd[0]) begin
                        r_t1  <= r_t1 + r_xa;
                        r_den <= r_den + r_xb;
                    end
                    if (r_ym[0]) r_t2 <= r_t2 + r_xb;
                    r_xa <= r_xa << 1;
                    r_xb <= r_xb << 1;
                    r_ym <= r_ym >> 1;
                    r_yd <= r_yd >> 1;
                    r_k  <= r_k + 1'b1;
                end
                rsmm_pkg::ST_ADD: begin
                    if (r_acc_num[A-1] == r_fs) begin
                        r_mag <= r_t1 + r_t2;
                        r_ga  <= r_t1 + r_t2;
                        r_sg  <= r_fs;
                    end else if (r_t1 >= r_t2) begin
                        r_mag <= r_t1 - r_t2;
                        r_ga  <= r_t1 - r_t2;
                        r_sg  <= r_acc_num[A-1];
                    end else begin
                        r_mag <= r_t2 - r_t1;
                        r_ga  <= r_t2 - r_t1;
                        r_sg  <= r_fs;
                    end
                    r_gb <= r_den;
                    r_k  <= '0;
                end
                rsmm_pkg::ST_GCD_PRE: begin
                    if (r_mag == '0) begin
                        r_acc_num <= '0;
                        r_acc_den <= A'(1);
                    end else if (!(r_ga[0] | r_gb[0])) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_k  <= r_k + 1'b1;
                    end
                end
                rsmm_pkg::ST_GCD_ODD_A: if (!r_ga[0]) r_ga <= r_ga >> 1;
                rsmm_pkg::ST_GCD_LOOP: begin
                    if (!r_gb[0]) r_gb <= r_gb >> 1;
                    else if (r_ga > r_gb) begin
                        r_ga <= r_gb;
                        r_gb <= r_ga - r_gb;
                    end else if (r_ga != r_gb) r_gb <= r_gb - r_ga;
                end
                rsmm_pkg::ST_GCD_SHL: begin
                    if (r_k != '0) begin
                        r_ga <= r_ga << 1;
                        r_k  <= r_k - 1'b1;
                    end
                end
                rsmm_pkg::ST_DIV_N: if (w_ddone) r_qn <= w_quo;
                rsmm_pkg::ST_DIV_D: begin
                    if (w_ddone) begin
                        r_ovl <= (r_qn[W-1:A] != '0) || (w_quo[W-1:A] != '0)
                                 || (w_quo[A-1:0] > w_lim)
                                 || (r_qn[A-1:0] > (r_sg ? w_lim + 1'b1 : w_lim));
                        r_gb  <= w_quo;
                    end
                end
                rsmm_pkg::ST_CMP: begin
                    if (r_mag != '0) begin
                        if (r_ovl) r_ovf <= 1'b1;
                        else begin
                            r_acc_num <= r_sg ? (~r_qn[A-1:0] + 1'b1) : r_qn[A-1:0];
                            r_acc_den <= r_gb[A-1:0];
                        end
                    end
                    if (!r_started) begin
                        r_hi_num  <= w_sn;
                        r_hi_den  <= r_md;
                        r_lo_num  <= w_sn;
                        r_lo_den  <= r_md;
                        r_started <= 1'b1;
                    end else begin
                        if (w_p1 > w_p2) begin
                            r_hi_num <= w_sn;
                            r_hi_den <= r_md;
                        end
                        if (w_p3 < w_p4) begin
                            r_lo_num <= w_sn;
                            r_lo_den <= r_md;
                        end
                    end
                end
                rsmm_pkg::ST_OUT: begin
                    if (w_out_go) begin
                        r_res.sum_num   <= r_acc_num;
                        r_res.sum_den   <= r_acc_den[A-2:0];
                        r_res.max_num   <= r_hi_num;
                        r_res.max_den   <= r_hi_den[I-1:0];
                        r_res.min_num   <= r_lo_num;
                        r_res.min_den   <= r_lo_den[I-1:0];
                        r_res.ovf       <= r_ovf;
                        r_res.bad       <= r_bad;
                        if (r_last) begin
                            r_acc_num <= '0;
                            r_acc_den <= A'(1);
                            r_hi_num  <= '0;
                            r_hi_den  <= (I+1)'(1);
                            r_lo_num  <= '0;
                            r_lo_den  <= (I+1)'(1);
                            r_ovf     <= 1'b0;
                            r_started <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tdata = {7'b0, r_res.min_den, r_res.min_num, r_res.max_den, r_res.max_num,
                           r_res.sum_den, r_res.sum_num};
    assign m_axis_tuser = {r_res.bad, r_res.ovf};
endmodule
